>>> rtl/pvuc_pkg.sv
// Shared widths, shape codes and stage records for the probe versus unit collision test.
`timescale 1ns / 1ps

package pvuc_pkg;

  // Default fraction width of the coordinate format.
  localparam int FRAC_BITS_DEF = 16;
  // Fraction width of the packed axis components (Q1.14).
  localparam int AXIS_FRAC = 14;

  // Field widths.
  localparam int CRD_W = 32;
  localparam int LEN_W = 31;
  localparam int AX_W = 16;
  localparam int KIND_W = 2;

  // Internal widths, each exact for every input pattern.
  localparam int DLT_W = CRD_W + 1;
  localparam int CONST_W = 32;
  localparam int HPROD_W = LEN_W + CONST_W;
  localparam int RS_W = LEN_W + 1;
  localparam int RS2_W = 2 * RS_W;
  localparam int LIM_W = LEN_W + 3;
  localparam int S2SQ_W = 2 * LIM_W;
  localparam int CSQ_W = 2 * DLT_W;
  localparam int PROJ_W = DLT_W + AX_W + 1;
  localparam int PQ_W = PROJ_W - AXIS_FRAC;
  localparam int PQA_W = PQ_W + AX_W;
  localparam int EX_W = PQA_W + 1;
  localparam int LO_W = 26;
  localparam int HI_W = EX_W - LO_W;
  localparam int PP_W = 2 * HI_W;
  localparam int LL_W = 2 * LO_W;
  localparam int SQ_W = 2 * EX_W + 2;
  localparam int R2_W = S2SQ_W + 2 * AXIS_FRAC - 2;

  // Pipeline depth: stage 0 takes the item, the last stage holds the result.
  localparam int NSTAGE = 8;
  localparam int MID_LAST = NSTAGE - 2;

  // Shape codes.
  localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOX = 2'd2;

  // Everything the first stage hands to the shape paths and the span check.
  typedef struct packed {
    logic signed [DLT_W-1:0] dx;
    logic signed [DLT_W-1:0] dz;
    logic signed [DLT_W-1:0] dy;
    logic [HPROD_W-1:0]      hprod;
    logic [RS_W-1:0]         rs;
    logic [LIM_W-1:0]        lim;
    logic [LIM_W-1:0]        s2;
    logic signed [AX_W-1:0]  ax;
    logic signed [AX_W-1:0]  az;
    logic [KIND_W-1:0]       kind;
  } front_t;

  // Box path terms that the last stage sums and compares.
  typedef struct packed {
    logic signed [SQ_W-1:0] ex2;
    logic signed [SQ_W-1:0] ez2;
    logic [R2_W-1:0]        r2;
    logic                   len_ok;
  } box_t;

endpackage

>>> rtl/probe_vs_unit_collision_test.sv
// Top level of the probe versus unit collision test: pipeline control, span check, result.
`timescale 1ns / 1ps

// Tests one circular probe against one map unit per item and returns a hit flag. The block
// takes one item every clock while the output is not stalled; its depth is that of the
// eight-stage pipeline, which places a register after every multiplier and splits the wide
// lateral squares into partial products. Each stage loads when it is empty or when the next
// stage moves on, so a stall on the output only backs up into stages that hold items and
// in_ready stays high while any stage is free. A hit needs the probe height inside the unit
// span (both bounds inclusive); shape kind 1 is the circle test, kind 2 the oriented box
// test, and kinds 0 and 3 always miss. All arithmetic is exact fixed point with FRAC_BITS
// fraction bits.

module probe_vs_unit_collision_test import pvuc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CRD_W-1:0] probe_x,
  input  logic signed [CRD_W-1:0] probe_y,
  input  logic signed [CRD_W-1:0] probe_z,
  input  logic [LEN_W-1:0]        probe_radius,
  input  logic signed [CRD_W-1:0] unit_x,
  input  logic signed [CRD_W-1:0] unit_y,
  input  logic signed [CRD_W-1:0] unit_z,
  input  logic [LEN_W-1:0]        unit_reach,
  input  logic [LEN_W-1:0]        unit_height,
  input  logic [LEN_W-1:0]        unit_side_radius,
  input  logic [CRD_W-1:0]        unit_axis,
  input  logic [KIND_W-1:0]       shape_kind,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit
);

  localparam int SPAN_W = DLT_W + 1;
  // 1.8 in the coordinate format, rounded to nearest.
  localparam logic [CONST_W-1:0] C18 = CONST_W'(((64'd18 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [NSTAGE-1:0]   vld;
  logic [NSTAGE-1:0]   en;
  front_t              s1;
  box_t                box_res;
  logic                circ_hit;
  logic [CONST_W-1:0]  top_off;
  logic [MID_LAST:1]   span_d;
  logic [KIND_W-1:0]   kind_d [1:MID_LAST];
  logic signed [SQ_W-1:0] e2;
  logic                box_hit;
  logic                hit_next;

  // Stage advance: a stage loads when empty or when the one after it loads.
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  pvuc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .en               (en[0]),
    .probe_x          (probe_x),
    .probe_y          (probe_y),
    .probe_z          (probe_z),
    .probe_radius     (probe_radius),
    .unit_x           (unit_x),
    .unit_y           (unit_y),
    .unit_z           (unit_z),
    .unit_reach       (unit_reach),
    .unit_height      (unit_height),
    .unit_side_radius (unit_side_radius),
    .unit_axis        (unit_axis),
    .shape_kind       (shape_kind),
    .s1               (s1)
  );

  pvuc_circle u_circle (
    .clk (clk),
    .en  (en[MID_LAST:1]),
    .s1  (s1),
    .hit (circ_hit)
  );

  pvuc_box u_box (
    .clk (clk),
    .en  (en[MID_LAST:1]),
    .s1  (s1),
    .res (box_res)
  );

  // Span top offset: floor of 0.9 times the unit height.
  assign top_off = CONST_W'(s1.hprod >> FRAC_BITS);

  // Vertical span check, then carry it and the shape code along.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      span_d[1] <= (SPAN_W'(s1.dy) <= $signed(SPAN_W'(top_off)))
                   && (SPAN_W'(s1.dy) >= -$signed(SPAN_W'(C18)));
      kind_d[1] <= s1.kind;
    end
    for (int k = 2; k <= MID_LAST; k++) begin
      if (en[k]) begin
        span_d[k] <= span_d[k-1];
        kind_d[k] <= kind_d[k-1];
      end
    end
  end

  // Final stage: side compare of the box and selection by shape.
  always_comb begin
    e2      = box_res.ex2 + box_res.ez2;
    box_hit = box_res.len_ok && (e2 < $signed(SQ_W'(box_res.r2)));
    case (kind_d[MID_LAST])
      KIND_CIRCLE: hit_next = span_d[MID_LAST] && circ_hit;
      KIND_BOX:    hit_next = span_d[MID_LAST] && box_hit;
      default:     hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      hit <= hit_next;
    end
  end

  // A full, stalled pipeline must not take another item.
  assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !out_ready) |-> !in_ready)
    else $error("item taken while every stage is full and stalled");

  // An empty output stage lets the whole pipeline move.
  assert property (@(posedge clk) disable iff (rst)
    !vld[NSTAGE-1] |-> in_ready)
    else $error("input held off with the output stage empty");

  // Items in flight change only by what enters and what leaves.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) == $past($countones(vld))
              + $past(32'(in_valid && in_ready)) - $past(32'(out_valid && out_ready))))
    else $error("item lost or repeated inside the pipeline");

endmodule

>>> rtl/pvuc_front.sv
// First pipeline stage: offsets, span product and the radius sums.
`timescale 1ns / 1ps

module pvuc_front import pvuc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CRD_W-1:0] probe_x,
  input  logic signed [CRD_W-1:0] probe_y,
  input  logic signed [CRD_W-1:0] probe_z,
  input  logic [LEN_W-1:0]        probe_radius,
  input  logic signed [CRD_W-1:0] unit_x,
  input  logic signed [CRD_W-1:0] unit_y,
  input  logic signed [CRD_W-1:0] unit_z,
  input  logic [LEN_W-1:0]        unit_reach,
  input  logic [LEN_W-1:0]        unit_height,
  input  logic [LEN_W-1:0]        unit_side_radius,
  input  logic [CRD_W-1:0]        unit_axis,
  input  logic [KIND_W-1:0]       shape_kind,
  output front_t                  s1
);

  // 0.9 in the coordinate format, rounded to nearest.
  localparam logic [CONST_W-1:0] C09 = CONST_W'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);

  // Register the differences, the scaled height and the summed radii.
  always_ff @(posedge clk) begin
    if (en) begin
      s1.dx    <= DLT_W'(probe_x) - DLT_W'(unit_x);
      s1.dz    <= DLT_W'(probe_z) - DLT_W'(unit_z);
      s1.dy    <= DLT_W'(probe_y) - DLT_W'(unit_y);
      s1.hprod <= HPROD_W'(unit_height) * HPROD_W'(C09);
      s1.rs    <= RS_W'(probe_radius) + RS_W'(unit_reach);
      // Twice the reach plus three probe radii: the 1.5 expansion kept exact.
      s1.lim   <= (LIM_W'(unit_reach) << 1) + (LIM_W'(probe_radius) << 1)
                  + LIM_W'(probe_radius);
      s1.s2    <= (LIM_W'(unit_side_radius) << 1) + (LIM_W'(probe_radius) << 1)
                  + LIM_W'(probe_radius);
      s1.ax    <= $signed(unit_axis[CRD_W-1:AX_W]);
      s1.az    <= $signed(unit_axis[AX_W-1:0]);
      s1.kind  <= shape_kind;
    end
  end

endmodule

>>> rtl/pvuc_circle.sv
// Circle path: squared x-z distance against the squared radius sum.
`timescale 1ns / 1ps

module pvuc_circle import pvuc_pkg::*; (
  input  logic              clk,
  input  logic [MID_LAST:1] en,
  input  front_t            s1,
  output logic              hit
);

  logic signed [CSQ_W-1:0] dx2;
  logic signed [CSQ_W-1:0] dz2;
  logic [RS2_W-1:0]        rs2;
  logic [MID_LAST:2]       chit;

  always_ff @(posedge clk) begin
    // Squares of both offsets and of the radius sum.
    if (en[1]) begin
      dx2 <= s1.dx * s1.dx;
      dz2 <= s1.dz * s1.dz;
      rs2 <= RS2_W'(s1.rs) * RS2_W'(s1.rs);
    end
    // Strict compare; both squares are non-negative.
    if (en[2]) begin
      chit[2] <= ({1'b0, dx2[CSQ_W-2:0]} + {1'b0, dz2[CSQ_W-2:0]}) < {2'b00, rs2};
    end
    // Carry the flag down to the stage where the shapes meet.
    for (int k = 3; k <= MID_LAST; k++) begin
      if (en[k]) begin
        chit[k] <= chit[k-1];
      end
    end
  end

  assign hit = chit[MID_LAST];

endmodule

>>> rtl/pvuc_box.sv
// Oriented box path: projection, length check, lateral offset and its split square.
`timescale 1ns / 1ps

module pvuc_box import pvuc_pkg::*; (
  input  logic              clk,
  input  logic [MID_LAST:1] en,
  input  front_t            s1,
  output box_t              res
);

  // Stage 1 registers.
  logic signed [PROJ_W-2:0] pxa;
  logic signed [PROJ_W-2:0] pza;
  logic [S2SQ_W-1:0]        s2sq_a;
  logic [LIM_W-1:0]         lim_a;
  logic signed [DLT_W-1:0]  dx_a;
  logic signed [DLT_W-1:0]  dz_a;
  logic signed [AX_W-1:0]   ax_a;
  logic signed [AX_W-1:0]   az_a;
  // Stage 2 registers.
  logic signed [PROJ_W-1:0] proj;
  logic [S2SQ_W-1:0]        s2sq_b;
  logic [LIM_W-1:0]         lim_b;
  logic signed [DLT_W-1:0]  dx_b;
  logic signed [DLT_W-1:0]  dz_b;
  logic signed [AX_W-1:0]   ax_b;
  logic signed [AX_W-1:0]   az_b;
  // Stage 3 registers.
  logic signed [PQA_W-1:0]  pqax;
  logic signed [PQA_W-1:0]  pqaz;
  logic                     len_c;
  logic [S2SQ_W-1:0]        s2sq_c;
  logic signed [DLT_W-1:0]  dx_c;
  logic signed [DLT_W-1:0]  dz_c;
  // Stage 4 registers.
  logic signed [EX_W-1:0]   ex;
  logic signed [EX_W-1:0]   ez;
  logic                     len_d;
  logic [S2SQ_W-1:0]        s2sq_d;
  // Stage 5 registers.
  logic signed [PP_W-1:0]   ex_hh;
  logic signed [PP_W-1:0]   ex_hl;
  logic [LL_W-1:0]          ex_ll;
  logic signed [PP_W-1:0]   ez_hh;
  logic signed [PP_W-1:0]   ez_hl;
  logic [LL_W-1:0]          ez_ll;
  logic                     len_e;
  logic [S2SQ_W-1:0]        s2sq_e;

  // Combinational helpers.
  logic signed [PQ_W-1:0]   pq;
  logic signed [PROJ_W-1:0] lpos;
  logic signed [HI_W-1:0]   exh;
  logic signed [HI_W-1:0]   exl;
  logic signed [HI_W-1:0]   ezh;
  logic signed [HI_W-1:0]   ezl;

  always_comb begin
    // Floor of the projection back to the coordinate format.
    pq   = PQ_W'(proj >>> AXIS_FRAC);
    // Half the length limit in the projection format.
    lpos = $signed(PROJ_W'(lim_b) << (AXIS_FRAC - 1));
    // Split the lateral offsets into a signed high and an unsigned low part.
    exh  = $signed(ex[EX_W-1:LO_W]);
    exl  = $signed({1'b0, ex[LO_W-1:0]});
    ezh  = $signed(ez[EX_W-1:LO_W]);
    ezl  = $signed({1'b0, ez[LO_W-1:0]});
  end

  always_ff @(posedge clk) begin
    // Axis products and the squared side limit.
    if (en[1]) begin
      pxa    <= s1.dx * s1.ax;
      pza    <= s1.dz * s1.az;
      s2sq_a <= S2SQ_W'(s1.s2) * S2SQ_W'(s1.s2);
      lim_a  <= s1.lim;
      dx_a   <= s1.dx;
      dz_a   <= s1.dz;
      ax_a   <= s1.ax;
      az_a   <= s1.az;
    end
    // Projection onto the axis.
    if (en[2]) begin
      proj   <= PROJ_W'(pxa) + PROJ_W'(pza);
      s2sq_b <= s2sq_a;
      lim_b  <= lim_a;
      dx_b   <= dx_a;
      dz_b   <= dz_a;
      ax_b   <= ax_a;
      az_b   <= az_a;
    end
    // Length check and the nearest axis point.
    if (en[3]) begin
      len_c  <= (proj <= lpos) && (proj >= -lpos);
      pqax   <= pq * ax_b;
      pqaz   <= pq * az_b;
      s2sq_c <= s2sq_b;
      dx_c   <= dx_b;
      dz_c   <= dz_b;
    end
    // Lateral offset from the axis line.
    if (en[4]) begin
      ex     <= (EX_W'(dx_c) << AXIS_FRAC) - EX_W'(pqax);
      ez     <= (EX_W'(dz_c) << AXIS_FRAC) - EX_W'(pqaz);
      len_d  <= len_c;
      s2sq_d <= s2sq_c;
    end
    // Partial products of the two squares.
    if (en[5]) begin
      ex_hh  <= exh * exh;
      ex_hl  <= exh * exl;
      ex_ll  <= LL_W'(ex[LO_W-1:0]) * LL_W'(ex[LO_W-1:0]);
      ez_hh  <= ezh * ezh;
      ez_hl  <= ezh * ezl;
      ez_ll  <= LL_W'(ez[LO_W-1:0]) * LL_W'(ez[LO_W-1:0]);
      len_e  <= len_d;
      s2sq_e <= s2sq_d;
    end
    // Assemble each square and scale the side limit to the offset format.
    if (en[6]) begin
      res.ex2    <= (SQ_W'(ex_hh) << (2 * LO_W)) + (SQ_W'(ex_hl) << (LO_W + 1))
                    + $signed(SQ_W'(ex_ll));
      res.ez2    <= (SQ_W'(ez_hh) << (2 * LO_W)) + (SQ_W'(ez_hl) << (LO_W + 1))
                    + $signed(SQ_W'(ez_ll));
      res.r2     <= R2_W'(s2sq_e) << (2 * AXIS_FRAC - 2);
      res.len_ok <= len_e;
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking bench for the probe versus unit collision test: edge-case and random pairs, hit flag checked against an in-bench model.
`timescale 1ns / 1ps

module testbench;
  import pvuc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint C09 = ((64'sd9 << FB) + 5) / 10;
  localparam longint C18 = ((64'sd18 << FB) + 5) / 10;
  localparam longint CRD_MAX = 64'sh7FFF_FFFF;
  localparam longint CRD_MIN = -64'sh8000_0000;
  localparam longint LEN_MAX = 64'sh7FFF_FFFF;
  localparam int RANDOM_PAIRS = 1450;
  localparam int CALM_TAIL = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 200;
  localparam int DRAIN_CYCLES = 24;

  // Kinds that never hit.
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Axis patterns: unit x, an unnormalized odd pair, and both components at the minimum.
  localparam logic [CRD_W-1:0] AXIS_X = 32'h4000_0000;
  localparam logic [CRD_W-1:0] AXIS_ODD = 32'h0003_0005;
  localparam logic [CRD_W-1:0] AXIS_MIN = 32'h8000_8000;

  typedef logic signed [159:0] wide_t;

  // One probe and unit pair, plus a flag that holds it back until the pipeline is empty.
  typedef struct packed {
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    logic signed [CRD_W-1:0] pz;
    logic [LEN_W-1:0]        prad;
    logic signed [CRD_W-1:0] ux;
    logic signed [CRD_W-1:0] uy;
    logic signed [CRD_W-1:0] uz;
    logic [LEN_W-1:0]        reach;
    logic [LEN_W-1:0]        height;
    logic [LEN_W-1:0]        side;
    logic [CRD_W-1:0]        axis;
    logic [KIND_W-1:0]       kind;
    logic                    drain;
  } pair_t;

  typedef struct packed {
    pair_t pair;
    logic  hit;
  } hit_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CRD_W-1:0] probe_x = '0;
  logic signed [CRD_W-1:0] probe_y = '0;
  logic signed [CRD_W-1:0] probe_z = '0;
  logic [LEN_W-1:0] probe_radius = '0;
  logic signed [CRD_W-1:0] unit_x = '0;
  logic signed [CRD_W-1:0] unit_y = '0;
  logic signed [CRD_W-1:0] unit_z = '0;
  logic [LEN_W-1:0] unit_reach = '0;
  logic [LEN_W-1:0] unit_height = '0;
  logic [LEN_W-1:0] unit_side_radius = '0;
  logic [CRD_W-1:0] unit_axis = '0;
  logic [KIND_W-1:0] shape_kind = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;

  pair_t pending_pairs[$];
  hit_expect_t hit_expected[$];

  int cycles = 0;
  logic [1:0] idle_odds = 2'd0;
  logic calm = 1'b0;
  int errors = 0;
  int reports = 0;
  int results = 0;
  int hits_seen = 0;
  int circle_items = 0;
  int box_items = 0;
  int dead_items = 0;
  int gap_left = 0;
  int stall_left = 0;
  int in_flight = 0;

  probe_vs_unit_collision_test dut (.*);

  always #4 clk = ~clk;

  // Exact hit decision for one pair, done in a datapath wide enough that nothing overflows.
  function automatic logic collides(pair_t p);
    wide_t px, py, pz, ux, uy, uz, prad, reach, height, side, ax, az;
    wide_t top, bottom, dx, dz, proj, mag, lim, pq, ex, ez, s2;
    logic res;
    px = $signed(p.px);
    py = $signed(p.py);
    pz = $signed(p.pz);
    ux = $signed(p.ux);
    uy = $signed(p.uy);
    uz = $signed(p.uz);
    prad = p.prad;
    reach = p.reach;
    height = p.height;
    side = p.side;
    ax = $signed(p.axis[31:16]);
    az = $signed(p.axis[15:0]);
    top = uy + ((height * C09) >>> FB);
    bottom = uy - C18;
    dx = px - ux;
    dz = pz - uz;
    res = 1'b0;
    if (py <= top && py >= bottom) begin
      if (p.kind == KIND_CIRCLE) begin
        res = (dx * dx + dz * dz) < ((prad + reach) * (prad + reach));
      end else if (p.kind == KIND_BOX) begin
        // Length along the axis first, then the lateral distance from the nearest axis point.
        proj = dx * ax + dz * az;
        mag = (proj < 0) ? -proj : proj;
        lim = (2 * reach + 3 * prad) <<< AXIS_FRAC;
        if (2 * mag <= lim) begin
          pq = proj >>> AXIS_FRAC;
          ex = (dx <<< AXIS_FRAC) - pq * ax;
          ez = (dz <<< AXIS_FRAC) - pq * az;
          s2 = 2 * side + 3 * prad;
          res = (ex * ex + ez * ez) < ((s2 * s2) <<< (2 * AXIS_FRAC - 2));
        end
      end
    end
    return res;
  endfunction

  // Uniform value in [-m, m].
  function automatic longint rnd_span(longint unsigned m);
    return longint'({$urandom, $urandom} % (2 * m + 1)) - longint'(m);
  endfunction

  task automatic add_pair(input longint px, input longint py, input longint pz,
                          input longint prad, input longint ux, input longint uy,
                          input longint uz, input longint reach, input longint height,
                          input longint side, input logic [CRD_W-1:0] axis,
                          input logic [KIND_W-1:0] kind);
    pair_t p;
    p = '0;
    p.px = px[31:0];
    p.py = py[31:0];
    p.pz = pz[31:0];
    p.prad = prad[30:0];
    p.ux = ux[31:0];
    p.uy = uy[31:0];
    p.uz = uz[31:0];
    p.reach = reach[30:0];
    p.height = height[30:0];
    p.side = side[30:0];
    p.axis = axis;
    p.kind = kind;
    pending_pairs.push_back(p);
  endtask

  // Cycle count, idle-rate phases and the run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 256 == 0) idle_odds <= $urandom_range(0, 3);
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Driver: feeds pending pairs, with random gaps and a full drain before marked items.
  always @(posedge clk) begin
    int busy;
    pair_t nx;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      in_flight = 0;
    end else begin
      busy = in_flight + (in_valid && in_ready) - (out_valid && out_ready);
      in_flight = busy;
      if (in_valid && !in_ready) begin
        // The current item waits for acceptance with its payload held.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_pairs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_pairs[0].drain && busy != 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_odds * 6) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(0, 4);
      end else begin
        nx = pending_pairs.pop_front();
        in_valid <= 1'b1;
        probe_x <= nx.px;
        probe_y <= nx.py;
        probe_z <= nx.pz;
        probe_radius <= nx.prad;
        unit_x <= nx.ux;
        unit_y <= nx.uy;
        unit_z <= nx.uz;
        unit_reach <= nx.reach;
        unit_height <= nx.height;
        unit_side_radius <= nx.side;
        unit_axis <= nx.axis;
        shape_kind <= nx.kind;
      end
    end
    calm <= (pending_pairs.size() < CALM_TAIL);
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < idle_odds * 6) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predicts every accepted item and checks every accepted result in order.
  always @(posedge clk) begin
    pair_t seen;
    hit_expect_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen = '0;
        seen.px = probe_x;
        seen.py = probe_y;
        seen.pz = probe_z;
        seen.prad = probe_radius;
        seen.ux = unit_x;
        seen.uy = unit_y;
        seen.uz = unit_z;
        seen.reach = unit_reach;
        seen.height = unit_height;
        seen.side = unit_side_radius;
        seen.axis = unit_axis;
        seen.kind = shape_kind;
        want.pair = seen;
        want.hit = collides(seen);
        hit_expected.push_back(want);
        if (shape_kind == KIND_CIRCLE) circle_items++;
        else if (shape_kind == KIND_BOX) box_items++;
        else dead_items++;
      end
      if (out_valid && out_ready) begin
        results++;
        if (hit === 1'b1) hits_seen++;
        if (hit_expected.size() == 0) begin
          errors++;
          if (reports < MAX_REPORTS)
            $display("%0t: result with no item pending, expected none, actual hit=%b",
                     $time, hit);
          reports++;
        end else begin
          want = hit_expected.pop_front();
          if (hit !== want.hit) begin
            errors++;
            if (reports < MAX_REPORTS)
              $display("%0t: hit mismatch, expected %b, actual %b (kind %0d, dx %0d, dz %0d)",
                       $time, want.hit, hit, want.pair.kind,
                       longint'(want.pair.px) - longint'(want.pair.ux),
                       longint'(want.pair.pz) - longint'(want.pair.uz));
            reports++;
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    pair_t pr;
    longint top_y, top, bottom, rs, dx, dz, ax_l, az_l, along, lateral, py;
    logic [31:0] lmask;
    int n, k, sel;

    // Circle: clear hit, tangency (a miss), just inside, and a 3-4-5 diagonal.
    add_pair(ONE, 0, 0, ONE, 0, 0, 0, ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);
    add_pair(2 * ONE, 0, 0, ONE, 0, 0, 0, ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);
    add_pair(2 * ONE - 1, 0, 0, ONE, 0, 0, 0, ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);
    add_pair(3 * ONE, 0, 4 * ONE, 2 * ONE, 0, 0, 0, 3 * ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);
    add_pair(3 * ONE, 0, 4 * ONE, 2 * ONE, 0, 0, 0, 3 * ONE + 1, 10 * ONE, 0, AXIS_X,
             KIND_CIRCLE);

    // Vertical span: on and just past the top and the bottom bound.
    top_y = (10 * ONE * C09) >>> FB;
    add_pair(0, top_y, 0, ONE, 0, 0, 0, ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);
    add_pair(0, top_y + 1, 0, ONE, 0, 0, 0, ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);
    add_pair(0, -C18, 0, ONE, 0, 0, 0, ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);
    add_pair(0, -C18 - 1, 0, ONE, 0, 0, 0, ONE, 10 * ONE, 0, AXIS_X, KIND_CIRCLE);

    // Unused kinds on a perfect overlap.
    add_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 10 * ONE, ONE, AXIS_X, KIND_IDLE);
    add_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 10 * ONE, ONE, AXIS_X, KIND_SPARE);

    // Box: end of the length, the side bound, and the 1.5 radius expansion on both.
    add_pair(4 * ONE, 0, 0, 0, 0, 0, 0, 4 * ONE, 10 * ONE, ONE, AXIS_X, KIND_BOX);
    add_pair(4 * ONE + 1, 0, 0, 0, 0, 0, 0, 4 * ONE, 10 * ONE, ONE, AXIS_X, KIND_BOX);
    add_pair(0, 0, ONE, 0, 0, 0, 0, 4 * ONE, 10 * ONE, ONE, AXIS_X, KIND_BOX);
    add_pair(0, 0, ONE - 1, 0, 0, 0, 0, 4 * ONE, 10 * ONE, ONE, AXIS_X, KIND_BOX);
    add_pair(0, 0, 3, 2, 0, 0, 0, 0, 10 * ONE, 0, AXIS_X, KIND_BOX);
    add_pair(0, 0, 2, 2, 0, 0, 0, 0, 10 * ONE, 0, AXIS_X, KIND_BOX);
    add_pair(3, 0, 0, 2, 0, 0, 0, 0, 10 * ONE, 0, AXIS_X, KIND_BOX);
    add_pair(4, 0, 0, 2, 0, 0, 0, 0, 10 * ONE, 0, AXIS_X, KIND_BOX);

    // Box with an unnormalized axis, a negative projection, and the most negative axis.
    add_pair(-1, 0, 0, ONE, 0, 0, 0, 4 * ONE, 10 * ONE, ONE, AXIS_ODD, KIND_BOX);
    add_pair(-ONE, 0, -ONE, ONE, 0, 0, 0, 4 * ONE, 10 * ONE, ONE, AXIS_MIN, KIND_BOX);

    // Field extremes, and all-zero pairs where the strict compares must miss.
    add_pair(CRD_MAX, CRD_MAX, CRD_MAX, LEN_MAX, CRD_MIN, CRD_MAX, CRD_MIN, LEN_MAX, LEN_MAX,
             LEN_MAX, 32'hFFFF_FFFF, KIND_CIRCLE);
    add_pair(CRD_MIN, CRD_MIN, CRD_MIN, LEN_MAX, CRD_MAX, CRD_MIN, CRD_MAX, LEN_MAX, LEN_MAX,
             LEN_MAX, 32'h7FFF_7FFF, KIND_BOX);
    add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0, KIND_CIRCLE);
    add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0, KIND_BOX);

    // Random pairs: mostly placed around the unit so both outcomes are common.
    for (n = 0; n < RANDOM_PAIRS; n++) begin
      pr = '0;
      pr.drain = (n == 0 || n == 600 || n == 1100);
      if ($urandom_range(0, 99) < 12) begin
        pr.px = $urandom;
        pr.py = $urandom;
        pr.pz = $urandom;
        pr.prad = $urandom;
        pr.ux = $urandom;
        pr.uy = $urandom;
        pr.uz = $urandom;
        pr.reach = $urandom;
        pr.height = $urandom;
        pr.side = $urandom;
        pr.axis = $urandom;
        pr.kind = $urandom;
      end else begin
        k = $urandom_range(1, 30);
        lmask = (32'd1 << k) - 1;
        pr.ux = $urandom;
        pr.uy = $urandom;
        pr.uz = $urandom;
        pr.prad = $urandom & lmask;
        pr.reach = $urandom & lmask;
        pr.height = $urandom & lmask;
        pr.side = $urandom & lmask;
        sel = $urandom_range(0, 19);
        pr.kind = (sel < 9) ? KIND_CIRCLE : (sel < 18) ? KIND_BOX :
                  (sel == 18) ? KIND_IDLE : KIND_SPARE;

        // Probe height inside the span, on a bound, one off a bound, or anywhere.
        top = longint'($signed(pr.uy)) + ((longint'(pr.height) * C09) >>> FB);
        bottom = longint'($signed(pr.uy)) - C18;
        case ($urandom_range(0, 5))
          0, 1, 2: py = ((top + bottom) >>> 1) + rnd_span((top - bottom) >>> 1);
          3:       py = top + $urandom_range(0, 2) - 1;
          4:       py = bottom + $urandom_range(0, 2) - 1;
          default: py = longint'($signed($urandom));
        endcase
        pr.py = py[31:0];

        rs = longint'(pr.prad) + longint'(pr.reach);
        if (pr.kind == KIND_BOX) begin
          case ($urandom_range(0, 9))
            0: begin ax_l = 16384;  az_l = 0;      end
            1: begin ax_l = 0;      az_l = 16384;  end
            2: begin ax_l = -16384; az_l = 0;      end
            3: begin ax_l = 11585;  az_l = 11585;  end
            4: begin ax_l = 11585;  az_l = -11585; end
            5: begin ax_l = 13107;  az_l = 9830;   end
            6: begin ax_l = -9830;  az_l = 13107;  end
            7: begin ax_l = 16383;  az_l = 181;    end
            default: begin
              pr.axis = $urandom;
              ax_l = longint'($signed(pr.axis[31:16]));
              az_l = longint'($signed(pr.axis[15:0]));
            end
          endcase
          pr.axis = {ax_l[15:0], az_l[15:0]};
          // Offset built from a position along the axis and one across it.
          along = rnd_span(longint'(pr.reach) + 3 * longint'(pr.prad) / 2 + rs / 4 + 2);
          lateral = rnd_span(longint'(pr.side) + 3 * longint'(pr.prad) / 2
                             + longint'(pr.side) / 4 + 2);
          dx = (along * ax_l - lateral * az_l) >>> AXIS_FRAC;
          dz = (along * az_l + lateral * ax_l) >>> AXIS_FRAC;
        end else begin
          pr.axis = $urandom;
          dx = rnd_span(rs + rs / 2 + 2);
          dz = rnd_span(rs + rs / 2 + 2);
        end
        dx = dx + longint'($signed(pr.ux));
        dz = dz + longint'($signed(pr.uz));
        pr.px = dx[31:0];
        pr.pz = dz[31:0];
      end
      pending_pairs.push_back(pr);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || hit_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (hit_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, hit_expected.size());
    end
    $display("Checked %0d hit flags, %0d of them hits, after %0d cycles.",
             results, hits_seen, cycles);
    $display("Items by shape: %0d circle, %0d oriented box, %0d unused kind; %0d errors.",
             circle_items, box_items, dead_items, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pvuc_pkg.sv
rtl/pvuc_front.sv
rtl/pvuc_circle.sv
rtl/pvuc_box.sv
rtl/probe_vs_unit_collision_test.sv
sim/testbench.sv
